// ===== hdl/sfba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfba_pkg
// Shared types and constants for the SRAM flow buffer allocator.
// ----------------------------------------------------------------------------
package sfba_pkg;

  localparam int MAX_FLOWS_DEF = 16;
  localparam int DIV_W         = 32;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_DIV    = 3'd1,
    ST_X4_FAIL   = 3'd2,
    ST_X2_FAIL   = 3'd3,
    ST_RAM_SHORT = 3'd4,
    ST_OVER_FLOW = 3'd5,
    ST_INVALID   = 3'd6
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_Q0,
    S_GCD_NEXT,
    S_GCD_STEP,
    S_GCD_MOD,
    S_DS_TEST,
    S_DS_EVAL,
    S_EQ_CHK,
    S_BUF_DIV,
    S_BUF_EVAL,
    S_BUF_MOD,
    S_BUF_CHARGE,
    S_GROW_TOP,
    S_GROW_ELEM,
    S_GROW_MOD,
    S_OUT_LOAD,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== hdl/sfba_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfba_in_if
// Flow size channel: valid/ready with one flow size per transfer.
// ----------------------------------------------------------------------------
interface sfba_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] flow_bytes;
  logic        last_flow;

  modport source (output valid, output flow_bytes, output last_flow, input ready);
  modport sink (input valid, input flow_bytes, input last_flow, output ready);
endinterface

// ===== hdl/sfba_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfba_out_if
// Allocation result channel: valid/ready with one buffer result per transfer.
// ----------------------------------------------------------------------------
interface sfba_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  flow_index;
  logic [31:0] buffer_bytes;
  logic [31:0] ram_left;
  logic [2:0]  status;
  logic        last_result;

  modport source (output valid, output flow_index, output buffer_bytes, output ram_left,
                  output status, output last_result, input ready);
  modport sink (input valid, input flow_index, input buffer_bytes, input ram_left,
                input status, input last_result, output ready);
endinterface

// ===== hdl/sfba_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfba_div
// Restoring divider, one quotient bit per cycle; quotient and remainder hold
// after done until the next start.
// ----------------------------------------------------------------------------
module sfba_div
  import sfba_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             done;

  logic [DIV_W:0]   rem_sh;
  logic [DIV_W+1:0] diff;

  assign rem_sh = {rem, quo[DIV_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      // subtract when the shifted remainder covers the divisor
      if (!diff[DIV_W+1]) begin
        rem <= diff[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// ===== hdl/sram_flow_buffer_allocator.sv =====
`timescale 1ns / 1ps
// A non-final flow transfer is stored and summed. The final flow starts an
// allocation pass built from divisions on one shared divider: one per gcd
// step, one per candidate d up to sqrt(gcd), one or two per flow for the
// buffers and one per doubling test; results then leave one at a time, each
// held until taken. Throughput: one set at a time; input is not ready
// during the pass. Reset (synchronous, rst high) clears control state and ram_size.
// ----------------------------------------------------------------------------
// sram_flow_buffer_allocator
// Collects flow sizes, then splits the RAM budget into per-flow buffers.
// ----------------------------------------------------------------------------
module sram_flow_buffer_allocator
  import sfba_pkg::*;
#(
  parameter int MAX_FLOWS = MAX_FLOWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  sfba_in_if.sink     flow_in,
  sfba_out_if.source  result_out
);

  localparam int CNT_W = $clog2(MAX_FLOWS + 2);
  localparam int IDX_W = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;

  state_t state, state_next, ret_state, ret_state_next;

  logic [31:0] flow_mem [MAX_FLOWS];
  logic [31:0] buf_mem  [MAX_FLOWS];

  logic [CNT_W-1:0]     count, count_next;
  logic [32:0]          total, total_next;
  logic [31:0]          ram_size;
  logic [31:0]          ram_rem, ram_rem_next;
  logic [31:0]          q0, q0_next;
  logic [31:0]          g, g_next;
  logic [31:0]          ga, ga_next;
  logic [31:0]          gb, gb_next;
  logic [16:0]          d, d_next;
  logic [32:0]          dsq, dsq_next;
  logic [31:0]          best, best_next;
  logic [31:0]          divisor, divisor_next;
  logic [CNT_W-1:0]     idx, idx_next;
  logic [MAX_FLOWS-1:0] mask, mask_next;
  logic [33:0]          bval, bval_next;
  status_t              pend_st, pend_st_next;

  logic        div_start, div_start_next;
  logic [31:0] div_a, div_a_next;
  logic [31:0] div_b, div_b_next;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  logic        out_valid, out_valid_next;
  logic [4:0]  out_idx, out_idx_next;
  logic [31:0] out_buf, out_buf_next;
  logic [31:0] out_ram, out_ram_next;
  status_t     out_st, out_st_next;
  logic        out_last, out_last_next;

  logic        buf_we;
  logic [31:0] buf_wdata;

  logic             in_xfer;
  logic             out_xfer;
  logic [IDX_W-1:0] idx_lo;
  logic [31:0]      f_rd;
  logic [31:0]      b_rd;
  logic [33:0]      sum;
  logic [32:0]      b2;
  logic [31:0]      best_a;
  logic             fail_en;
  status_t          fail_code;

  assign in_xfer  = flow_in.valid && flow_in.ready;
  assign out_xfer = out_valid && result_out.ready;
  assign idx_lo   = idx[IDX_W-1:0];
  assign f_rd     = flow_mem[idx_lo];
  assign b_rd     = buf_mem[idx_lo];
  assign sum      = {1'b0, total} + {2'b00, flow_in.flow_bytes};
  assign b2       = {b_rd, 1'b0};

  assign flow_in.ready = (state == S_IDLE);

  assign div_req.start    = div_start;
  assign div_req.dividend = div_a;
  assign div_req.divisor  = div_b;

  sfba_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    state_next     = state;
    ret_state_next = ret_state;
    count_next     = count;
    total_next     = total;
    ram_rem_next   = ram_rem;
    q0_next        = q0;
    g_next         = g;
    ga_next        = ga;
    gb_next        = gb;
    d_next         = d;
    dsq_next       = dsq;
    best_next      = best;
    divisor_next   = divisor;
    idx_next       = idx;
    mask_next      = mask;
    bval_next      = bval;
    pend_st_next   = pend_st;
    div_start_next = 1'b0;
    div_a_next     = div_a;
    div_b_next     = div_b;
    out_valid_next = out_valid;
    out_idx_next   = out_idx;
    out_buf_next   = out_buf;
    out_ram_next   = out_ram;
    out_st_next    = out_st;
    out_last_next  = out_last;
    buf_we         = 1'b0;
    buf_wdata      = '0;
    fail_en        = 1'b0;
    fail_code      = ST_INVALID;
    best_a         = best;

    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          if (count < CNT_W'(MAX_FLOWS)) begin
            count_next = count + 1'b1;
          end else begin
            count_next = CNT_W'(MAX_FLOWS + 1);
          end
          // saturate: bit 32 marks an overflowed sum
          if (sum[33:32] != 2'b00) begin
            total_next = {1'b1, 32'd0};
          end else begin
            total_next = sum[32:0];
          end
          if (flow_in.last_flow) begin
            state_next = S_CHECK;
          end
        end
      end

      S_CHECK: begin
        ram_rem_next = ram_size;
        if (count > CNT_W'(MAX_FLOWS) || ram_size == '0 || total == '0 || total[32]) begin
          fail_en   = 1'b1;
          fail_code = ST_INVALID;
        end else begin
          div_start_next = 1'b1;
          div_a_next     = total[31:0];
          div_b_next     = ram_size;
          ret_state_next = S_Q0;
          state_next     = S_DIV;
        end
      end

      S_DIV: begin
        if (div_rsp.done) begin
          state_next = ret_state;
        end
      end

      S_Q0: begin
        q0_next    = div_rsp.quotient + {31'd0, (div_rsp.remainder != '0)};
        g_next     = '0;
        idx_next   = '0;
        state_next = S_GCD_NEXT;
      end

      S_GCD_NEXT: begin
        if (idx == count) begin
          d_next     = 17'd1;
          dsq_next   = 33'd1;
          best_next  = '0;
          state_next = S_DS_TEST;
        end else begin
          ga_next    = g;
          gb_next    = f_rd;
          idx_next   = idx + 1'b1;
          state_next = S_GCD_STEP;
        end
      end

      S_GCD_STEP: begin
        if (gb == '0) begin
          g_next     = ga;
          state_next = S_GCD_NEXT;
        end else begin
          div_start_next = 1'b1;
          div_a_next     = ga;
          div_b_next     = gb;
          ret_state_next = S_GCD_MOD;
          state_next     = S_DIV;
        end
      end

      S_GCD_MOD: begin
        ga_next    = gb;
        gb_next    = div_rsp.remainder;
        state_next = S_GCD_STEP;
      end

      S_DS_TEST: begin
        if (dsq > {1'b0, g}) begin
          if (best == '0) begin
            fail_en   = 1'b1;
            fail_code = ST_NO_DIV;
          end else begin
            divisor_next = best;
            idx_next     = '0;
            state_next   = S_EQ_CHK;
          end
        end else begin
          div_start_next = 1'b1;
          div_a_next     = g;
          div_b_next     = {15'd0, d};
          ret_state_next = S_DS_EVAL;
          state_next     = S_DIV;
        end
      end

      S_DS_EVAL: begin
        if (div_rsp.remainder == '0) begin
          if ({15'd0, d} >= q0 && (best == '0 || {15'd0, d} < best)) begin
            best_a = {15'd0, d};
          end
          if (div_rsp.quotient >= q0 && (best_a == '0 || div_rsp.quotient < best_a)) begin
            best_next = div_rsp.quotient;
          end else begin
            best_next = best_a;
          end
        end
        d_next     = d + 1'b1;
        dsq_next   = dsq + {15'd0, d, 1'b1};
        state_next = S_DS_TEST;
      end

      S_EQ_CHK: begin
        if (idx == count) begin
          idx_next   = '0;
          state_next = S_BUF_DIV;
        end else if (f_rd == divisor) begin
          fail_en   = 1'b1;
          fail_code = ST_NO_DIV;
        end else begin
          idx_next = idx + 1'b1;
        end
      end

      S_BUF_DIV: begin
        if (idx == count) begin
          for (int i = 0; i < MAX_FLOWS; i++) begin
            mask_next[i] = (CNT_W'(i) < count);
          end
          state_next = S_GROW_TOP;
        end else begin
          div_start_next = 1'b1;
          div_a_next     = f_rd;
          div_b_next     = divisor;
          ret_state_next = S_BUF_EVAL;
          state_next     = S_DIV;
        end
      end

      S_BUF_EVAL: begin
        if (div_rsp.quotient[1:0] != 2'b00) begin
          // align: odd buffers take x4, 2 mod 4 buffers take x2
          if (div_rsp.quotient[0]) begin
            bval_next    = {div_rsp.quotient, 2'b00};
            pend_st_next = ST_X4_FAIL;
          end else begin
            bval_next    = {1'b0, div_rsp.quotient, 1'b0};
            pend_st_next = ST_X2_FAIL;
          end
          if (!({2'b00, ram_rem} > bval_next && {2'b00, f_rd} >= bval_next)) begin
            fail_en   = 1'b1;
            fail_code = pend_st_next;
          end else begin
            div_start_next = 1'b1;
            div_a_next     = f_rd;
            div_b_next     = bval_next[31:0];
            ret_state_next = S_BUF_MOD;
            state_next     = S_DIV;
          end
        end else begin
          bval_next  = {2'b00, div_rsp.quotient};
          state_next = S_BUF_CHARGE;
        end
      end

      S_BUF_MOD: begin
        if (div_rsp.remainder != '0) begin
          fail_en   = 1'b1;
          fail_code = pend_st;
        end else begin
          state_next = S_BUF_CHARGE;
        end
      end

      S_BUF_CHARGE: begin
        if ({2'b00, ram_rem} < bval) begin
          fail_en   = 1'b1;
          fail_code = ST_RAM_SHORT;
        end else begin
          ram_rem_next = ram_rem - bval[31:0];
          buf_we       = 1'b1;
          buf_wdata    = bval[31:0];
          idx_next     = idx + 1'b1;
          state_next   = S_BUF_DIV;
        end
      end

      S_GROW_TOP: begin
        idx_next = '0;
        if (mask == '0) begin
          state_next = S_OUT_LOAD;
        end else begin
          state_next = S_GROW_ELEM;
        end
      end

      S_GROW_ELEM: begin
        if (idx == count) begin
          state_next = S_GROW_TOP;
        end else begin
          if (b_rd == f_rd) begin
            mask_next[idx_lo] = 1'b0;
          end
          if (b_rd > ram_rem) begin
            mask_next[idx_lo] = 1'b0;
            if (b_rd > f_rd) begin
              fail_en   = 1'b1;
              fail_code = ST_OVER_FLOW;
            end else begin
              idx_next = idx + 1'b1;
            end
          end else if (f_rd > b_rd) begin
            if (b_rd != '0 && b2 <= {1'b0, f_rd}) begin
              div_start_next = 1'b1;
              div_a_next     = f_rd;
              div_b_next     = b2[31:0];
              ret_state_next = S_GROW_MOD;
              state_next     = S_DIV;
            end else begin
              // doubled size cannot divide the flow
              mask_next[idx_lo] = 1'b0;
              idx_next          = idx + 1'b1;
            end
          end else if (b_rd > f_rd) begin
            fail_en   = 1'b1;
            fail_code = ST_OVER_FLOW;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end

      S_GROW_MOD: begin
        if (div_rsp.remainder == '0) begin
          ram_rem_next = ram_rem - b_rd;
          buf_we       = 1'b1;
          buf_wdata    = b2[31:0];
        end else begin
          mask_next[idx_lo] = 1'b0;
        end
        idx_next   = idx + 1'b1;
        state_next = S_GROW_ELEM;
      end

      S_OUT_LOAD: begin
        out_valid_next = 1'b1;
        out_idx_next   = 5'(idx);
        out_buf_next   = b_rd;
        out_ram_next   = ram_rem;
        out_st_next    = ST_OK;
        out_last_next  = (CNT_W'(idx + 1'b1) == count);
        state_next     = S_EMIT;
      end

      S_EMIT: begin
        if (out_xfer) begin
          out_valid_next = 1'b0;
          if (out_last) begin
            count_next = '0;
            total_next = '0;
            state_next = S_IDLE;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = S_OUT_LOAD;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (fail_en) begin
      out_valid_next = 1'b1;
      out_idx_next   = '0;
      out_buf_next   = '0;
      out_ram_next   = ram_rem_next;
      out_st_next    = fail_code;
      out_last_next  = 1'b1;
      state_next     = S_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      total     <= '0;
      ram_size  <= '0;
      ram_rem   <= '0;
      mask      <= '0;
      div_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      total     <= total_next;
      ram_rem   <= ram_rem_next;
      mask      <= mask_next;
      div_start <= div_start_next;
      out_valid <= out_valid_next;
      if (cfg_wr_en) begin
        ram_size <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ret_state <= ret_state_next;
    q0        <= q0_next;
    g         <= g_next;
    ga        <= ga_next;
    gb        <= gb_next;
    d         <= d_next;
    dsq       <= dsq_next;
    best      <= best_next;
    divisor   <= divisor_next;
    idx       <= idx_next;
    bval      <= bval_next;
    pend_st   <= pend_st_next;
    div_a     <= div_a_next;
    div_b     <= div_b_next;
    out_idx   <= out_idx_next;
    out_buf   <= out_buf_next;
    out_ram   <= out_ram_next;
    out_st    <= out_st_next;
    out_last  <= out_last_next;
  end

  // flow and buffer store: drop flows beyond the table
  always_ff @(posedge clk) begin
    if (in_xfer && count < CNT_W'(MAX_FLOWS)) begin
      flow_mem[count[IDX_W-1:0]] <= flow_in.flow_bytes;
    end
    if (buf_we) begin
      buf_mem[idx_lo] <= buf_wdata;
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.flow_index   = out_idx;
  assign result_out.buffer_bytes = out_buf;
  assign result_out.ram_left     = out_ram;
  assign result_out.status       = out_st;
  assign result_out.last_result  = out_last;

`ifndef SYNTHESIS
  a_ready_no_result: assert property (@(posedge clk) disable iff (rst)
    flow_in.ready |-> !result_out.valid)
    else $error("input ready while a result is pending");

  a_div_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_start |-> state == S_DIV)
    else $error("divider started outside the wait state");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && result_out.ready && result_out.last_result) |=> flow_in.ready)
    else $error("no return to collecting after final result");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_FLOWS + 1))
    else $error("flow count out of range");
`endif

endmodule

// ===== test/sram_flow_buffer_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sram_flow_buffer_allocator_tb
// Loads sets of flow sizes under several RAM budgets and checks every buffer
// result against a cycle-free allocation predictor. Both channels idle and
// stall at random.
// ----------------------------------------------------------------------------
module sram_flow_buffer_allocator_tb;
  import sfba_pkg::*;

  localparam int  NFLOWS    = MAX_FLOWS_DEF;
  localparam int  CYC_LIMIT = 40_000_000;
  localparam int  DRAIN_CYC = 40;

  typedef struct {
    logic [4:0]  flow_index;
    logic [31:0] buffer_bytes;
    logic [31:0] ram_left;
    status_t     status;
    logic        last_result;
  } alloc_result_t;

  class alloc_scoreboard;
    bit [31:0]       ram_size;
    bit [31:0]       flow_tab[NFLOWS];
    bit [31:0]       buf_tab[NFLOWS];
    int unsigned     flow_cnt;
    longint unsigned size_sum;
    bit [31:0]       ram_free;
    alloc_result_t   expected_allocs[$];
    int              mismatches;
    int              results_seen;
    int              sets_done;

    function void set_ram(bit [31:0] v);
      ram_size = v;
    endfunction

    function void push_error(status_t st);
      alloc_result_t r;
      r.flow_index   = '0;
      r.buffer_bytes = '0;
      r.ram_left     = ram_free;
      r.status       = st;
      r.last_result  = 1'b1;
      expected_allocs.push_back(r);
    endfunction

    function bit [31:0] gcd(bit [31:0] a, bit [31:0] b);
      bit [31:0] t;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      return a;
    endfunction

    function void allocate();
      int unsigned     n;
      bit [31:0]       total, q0, g, best;
      longint unsigned d, e, f, b, m;
      bit [NFLOWS-1:0] grow;
      alloc_result_t   r;
      ram_free = ram_size;
      if (flow_cnt > NFLOWS || ram_size == 0 || size_sum == 0 || size_sum > 64'hFFFF_FFFF) begin
        push_error(ST_INVALID);
        return;
      end
      n     = flow_cnt;
      total = size_sum[31:0];
      q0    = total / ram_size + ((total % ram_size) != 0);
      g = 0;
      for (int i = 0; i < n; i++) g = gcd(g, flow_tab[i]);
      best = 0;
      for (d = 1; d * d <= g; d++) begin
        if (g % d == 0) begin
          e = g / d;
          if (d >= q0 && (best == 0 || d < best)) best = d[31:0];
          if (e >= q0 && (best == 0 || e < best)) best = e[31:0];
        end
      end
      if (best == 0) begin
        push_error(ST_NO_DIV);
        return;
      end
      for (int i = 0; i < n; i++)
        if (flow_tab[i] == best) begin
          push_error(ST_NO_DIV);
          return;
        end
      for (int i = 0; i < n; i++) begin
        f = flow_tab[i];
        b = f / best;
        if (b[1:0] != 0) begin
          m = b[0] ? b * 4 : b * 2;
          if (!(ram_free > m && f >= m && m != 0 && f % m == 0)) begin
            push_error(b[0] ? ST_X4_FAIL : ST_X2_FAIL);
            return;
          end
          b = m;
        end
        if (ram_free < b) begin
          push_error(ST_RAM_SHORT);
          return;
        end
        ram_free  -= b[31:0];
        buf_tab[i] = b[31:0];
      end
      grow = '0;
      for (int i = 0; i < n; i++) grow[i] = 1'b1;
      while (grow != 0) begin
        for (int i = 0; i < n; i++) begin
          f = flow_tab[i];
          b = buf_tab[i];
          if (b == f) grow[i] = 1'b0;
          if (b > ram_free) begin
            grow[i] = 1'b0;
          end else if (f > b) begin
            if (b != 0 && f % (b * 2) == 0) begin
              ram_free  -= b[31:0];
              b          = b * 2;
              buf_tab[i] = b[31:0];
            end else begin
              grow[i] = 1'b0;
            end
          end
          if (b > f) begin
            push_error(ST_OVER_FLOW);
            return;
          end
        end
      end
      for (int i = 0; i < n; i++) begin
        r.flow_index   = i[4:0];
        r.buffer_bytes = buf_tab[i];
        r.ram_left     = ram_free;
        r.status       = ST_OK;
        r.last_result  = (i + 1 == n);
        expected_allocs.push_back(r);
      end
    endfunction

    function void note_flow(bit [31:0] fsize, bit last);
      if (flow_cnt < NFLOWS) begin
        flow_tab[flow_cnt] = fsize;
        flow_cnt++;
      end else begin
        flow_cnt = NFLOWS + 1;
      end
      size_sum += fsize;
      if (size_sum > 64'hFFFF_FFFF) size_sum = 64'h1_0000_0000;
      if (last) begin
        allocate();
        flow_cnt = 0;
        size_sum = 0;
        sets_done++;
      end
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t exp_r;
      results_seen++;
      if (expected_allocs.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result idx=%0d bytes=%0h left=%0h st=%0d last=%0b", $time,
                 got.flow_index, got.buffer_bytes, got.ram_left, got.status, got.last_result);
        return;
      end
      exp_r = expected_allocs.pop_front();
      if (got.flow_index !== exp_r.flow_index) begin
        mismatches++;
        $display("%0t: flow_index expected %0d actual %0d", $time, exp_r.flow_index,
                 got.flow_index);
      end
      if (got.buffer_bytes !== exp_r.buffer_bytes) begin
        mismatches++;
        $display("%0t: buffer_bytes expected %0h actual %0h", $time, exp_r.buffer_bytes,
                 got.buffer_bytes);
      end
      if (got.ram_left !== exp_r.ram_left) begin
        mismatches++;
        $display("%0t: ram_left expected %0h actual %0h", $time, exp_r.ram_left, got.ram_left);
      end
      if (got.status !== exp_r.status) begin
        mismatches++;
        $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
      end
      if (got.last_result !== exp_r.last_result) begin
        mismatches++;
        $display("%0t: last_result expected %0b actual %0b", $time, exp_r.last_result,
                 got.last_result);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  int          cycles = 0;
  bit          steady = 1'b0;
  int          flows_sent = 0;

  sfba_in_if  flow_in ();
  sfba_out_if result_out ();

  alloc_scoreboard alloc_sb = new();

  sram_flow_buffer_allocator dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .flow_in    (flow_in.sink),
    .result_out (result_out.source)
  );

  always #10 clk = ~clk;

  initial begin
    flow_in.valid      = 1'b0;
    flow_in.flow_bytes = '0;
    flow_in.last_flow  = 1'b0;
    result_out.ready   = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result sink: check on transfer, then stall at random
  always @(posedge clk) begin
    alloc_result_t got;
    if (!rst && result_out.valid && result_out.ready) begin
      got.flow_index   = result_out.flow_index;
      got.buffer_bytes = result_out.buffer_bytes;
      got.ram_left     = result_out.ram_left;
      got.status       = status_t'(result_out.status);
      got.last_result  = result_out.last_result;
      alloc_sb.check_result(got);
    end
    result_out.ready <= steady || ($urandom_range(99) >= 37);
  end

  // valid stays up after a transfer; the next idle or drain drops it
  task automatic send_flow(bit [31:0] fsize, bit last);
    if (!steady && $urandom_range(99) < 37) begin
      flow_in.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    flow_in.valid      <= 1'b1;
    flow_in.flow_bytes <= fsize;
    flow_in.last_flow  <= last;
    do @(posedge clk); while (!flow_in.ready);
    alloc_sb.note_flow(fsize, last);
    flows_sent++;
  endtask

  task automatic wait_drained();
    flow_in.valid <= 1'b0;
    while (alloc_sb.expected_allocs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_ram(bit [31:0] v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    alloc_sb.set_ram(v);
  endtask

  // mostly sets with a shared factor so the pass gets past the divisor search
  task automatic random_set();
    int          kind, n;
    bit [31:0]   base;
    kind = $urandom_range(99);
    if (kind < 80) begin
      n    = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, NFLOWS);
      base = $urandom_range(1, 64);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(19) == 0)
          send_flow(0, i == n - 1);
        else
          send_flow(base * (1 << $urandom_range(0, 6)) * $urandom_range(1, 15), i == n - 1);
      end
    end else if (kind < 92) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) send_flow($urandom(), i == n - 1);
    end else begin
      n = $urandom_range(NFLOWS + 1, NFLOWS + 4);
      for (int i = 0; i < n; i++) send_flow($urandom_range(1, 4096), i == n - 1);
    end
  endtask

  initial begin
    bit [31:0] ram_pick[7];
    ram_pick = '{32'd1, 32'h40, 32'h1000, 32'h1_0000, 32'h10_0000, 32'hFFFF_FFFF, 32'd0};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero RAM after reset, then the edges of the flow fields
    send_flow(5, 1'b1);
    write_ram(32'hFFFF_FFFF);
    send_flow(32'hFFFF_FFFE, 1'b0);
    send_flow(1, 1'b1);
    send_flow(32'hFFFF_FFFF, 1'b0);
    send_flow(1, 1'b1);
    send_flow(0, 1'b1);
    send_flow(64, 1'b0);
    send_flow(128, 1'b0);
    send_flow(0, 1'b1);
    send_flow(3, 1'b0);
    send_flow(6, 1'b1);
    send_flow(6, 1'b0);
    send_flow(12, 1'b1);
    write_ram(32'd10);
    send_flow(4, 1'b0);
    send_flow(8, 1'b1);
    write_ram(32'd5);
    send_flow(8, 1'b0);
    send_flow(8, 1'b1);
    for (int i = 0; i < NFLOWS + 1; i++) send_flow(32'd16, i == NFLOWS);

    // hold the sender until the block has delivered everything
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 7) write_ram(ram_pick[ph]);
      else write_ram($urandom_range(32'h100, 32'h4_0000));
      steady = (ph == 3);
      while (flows_sent < 30 + (ph + 1) * 50) random_set();
    end
    steady = 1'b0;

    wait_drained();
    $display("covered %0d flow transfers in %0d sets, %0d results checked", flows_sent,
             alloc_sb.sets_done, alloc_sb.results_seen);
    $display("RAM budgets from zero to full scale, error and success paths");
    if (alloc_sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
